>>> hdl/tew_pkg.sv
package tew_pkg;

  localparam int CFG_WIDTH         = 32;
  localparam int COUNT_WIDTH_DEF   = 32;
  localparam int CFG_ADDR_WIDTH    = 2;

  localparam logic [5:0] SIG_KILL     = 6'd9;
  localparam logic [5:0] SIG_TERM     = 6'd15;
  localparam logic [7:0] CODE_TIMEOUT = 8'd124;
  localparam logic [7:0] CODE_FAULT   = 8'd125;
  localparam logic [7:0] CODE_SIGBASE = 8'd128;
  localparam logic [7:0] CODE_KILLED  = 8'd137;

  typedef enum logic [2:0] {
    REQ_START  = 3'd0,
    REQ_TICK   = 3'd1,
    REQ_SIGNAL = 3'd2,
    REQ_ENDED  = 3'd3,
    REQ_FAULT  = 3'd4
  } req_type_t;

  typedef enum logic [1:0] {
    EXIT_NORMAL = 2'd0,
    EXIT_SIGNAL = 2'd1
  } exit_kind_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_RUN    = 3'd1,
    PH_TERM   = 3'd2,
    PH_KILLED = 3'd3,
    PH_INTR   = 3'd4
  } phase_t;

  typedef enum logic [CFG_ADDR_WIDTH-1:0] {
    CFG_TIMEOUT = 2'd0,
    CFG_GRACE   = 2'd1,
    CFG_KILL    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [5:0] caller_sig;
    logic [1:0] exit_kind;
    logic [7:0] exit_value;
  } tew_in_t;

  typedef struct packed {
    logic       send_signal;
    logic [5:0] sig_num;
    logic       finished;
    logic [7:0] exit_code;
  } tew_out_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] timeout_ticks;
    logic [CFG_WIDTH-1:0] grace_ticks;
    logic                 kill_on_timeout;
  } tew_cfg_t;

endpackage

>>> hdl/timeout_escalation_watchdog.sv
// A result is registered: it is valid in the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle; the single output register is refilled
// in the cycle it is drained, so the input stalls only while the output stalls.
// Reset (rst, synchronous): phase idle, countdown and interrupt signal zero,
// configuration registers zero, output register empty.
module timeout_escalation_watchdog import tew_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  tew_in_t                   in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output tew_out_t                  out_data,
  input  logic                      cfg_en,
  input  logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
  input  logic [CFG_WIDTH-1:0]      cfg_data
);

  tew_cfg_t cfg;
  tew_out_t result;
  logic     accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_en) begin
      case (cfg_addr)
        CFG_TIMEOUT: cfg.timeout_ticks   <= cfg_data;
        CFG_GRACE:   cfg.grace_ticks     <= cfg_data;
        CFG_KILL:    cfg.kill_on_timeout <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tew_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (in_data),
    .cfg    (cfg),
    .result (result)
  );

  // hold the result until taken; refill on the same edge it drains
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

endmodule

>>> hdl/tew_core.sv
module tew_core import tew_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  tew_in_t  req,
  input  tew_cfg_t cfg,
  output tew_out_t result
);

  phase_t                 phase, phase_next;
  logic [COUNT_WIDTH-1:0] countdown, countdown_next;
  logic [5:0]             interrupt_sig, interrupt_sig_next;

  logic [COUNT_WIDTH-1:0] timeout_load;
  logic [COUNT_WIDTH-1:0] grace_load;
  logic [COUNT_WIDTH-1:0] count_dec;
  logic                   expired;
  logic [8:0]             sig_sum;
  logic [7:0]             end_code;

  // saturate the configured counts into the counter width
  generate
    if (COUNT_WIDTH >= CFG_WIDTH) begin : g_wide
      assign timeout_load = COUNT_WIDTH'(cfg.timeout_ticks);
      assign grace_load   = COUNT_WIDTH'(cfg.grace_ticks);
    end else begin : g_narrow
      assign timeout_load = (|cfg.timeout_ticks[CFG_WIDTH-1:COUNT_WIDTH]) ?
                            '1 : cfg.timeout_ticks[COUNT_WIDTH-1:0];
      assign grace_load   = (|cfg.grace_ticks[CFG_WIDTH-1:COUNT_WIDTH]) ?
                            '1 : cfg.grace_ticks[COUNT_WIDTH-1:0];
    end
  endgenerate

  assign count_dec = (countdown != '0) ? countdown - COUNT_WIDTH'(1) : countdown;
  assign expired   = (count_dec == '0);
  assign sig_sum   = {1'b0, CODE_SIGBASE} + {1'b0, req.exit_value};

  // exit code for a child that ended
  always_comb begin
    unique case (phase)
      PH_RUN: begin
        if (req.exit_kind == EXIT_NORMAL) begin
          end_code = req.exit_value;
        end else if (req.exit_kind == EXIT_SIGNAL) begin
          end_code = sig_sum[8] ? 8'hFF : sig_sum[7:0];
        end else begin
          end_code = CODE_FAULT;
        end
      end
      PH_TERM:   end_code = CODE_TIMEOUT;
      PH_KILLED: end_code = CODE_KILLED;
      default:   end_code = CODE_SIGBASE + {2'b00, interrupt_sig};
    endcase
  end

  // next state
  always_comb begin
    phase_next         = phase;
    countdown_next     = countdown;
    interrupt_sig_next = interrupt_sig;
    if (req.req_type == REQ_START) begin
      phase_next         = PH_RUN;
      countdown_next     = timeout_load;
      interrupt_sig_next = '0;
    end else if (phase != PH_IDLE) begin
      case (req.req_type)
        REQ_TICK: begin
          countdown_next = count_dec;
          if (expired) begin
            if (phase == PH_RUN) begin
              if (cfg.kill_on_timeout) begin
                phase_next = PH_KILLED;
              end else begin
                phase_next     = PH_TERM;
                countdown_next = grace_load;
              end
            end else if (phase == PH_TERM) begin
              phase_next = PH_KILLED;
            end
          end
        end
        REQ_SIGNAL: begin
          if (req.caller_sig != '0 && phase != PH_INTR) begin
            phase_next         = PH_INTR;
            countdown_next     = grace_load;
            interrupt_sig_next = req.caller_sig;
          end
        end
        REQ_ENDED, REQ_FAULT: begin
          phase_next         = PH_IDLE;
          countdown_next     = '0;
          interrupt_sig_next = '0;
        end
        default: ;
      endcase
    end
  end

  // result for this transaction
  always_comb begin
    result = '0;
    if (phase != PH_IDLE) begin
      case (req.req_type)
        REQ_TICK: begin
          if (expired) begin
            if (phase == PH_RUN) begin
              result.send_signal = 1'b1;
              result.sig_num     = cfg.kill_on_timeout ? SIG_KILL : SIG_TERM;
            end else if (phase == PH_TERM || phase == PH_INTR) begin
              result.send_signal = 1'b1;
              result.sig_num     = SIG_KILL;
            end
          end
        end
        REQ_SIGNAL: begin
          if (req.caller_sig != '0 && phase != PH_INTR) begin
            result.send_signal = 1'b1;
            result.sig_num     = req.caller_sig;
          end
        end
        REQ_ENDED: begin
          result.send_signal = 1'b1;
          result.sig_num     = SIG_KILL;
          result.finished    = 1'b1;
          result.exit_code   = end_code;
        end
        REQ_FAULT: begin
          result.send_signal = 1'b1;
          result.sig_num     = SIG_KILL;
          result.finished    = 1'b1;
          result.exit_code   = CODE_FAULT;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      countdown     <= '0;
      interrupt_sig <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      countdown     <= countdown_next;
      interrupt_sig <= interrupt_sig_next;
    end
  end

endmodule

>>> dv/testbench.sv
module testbench;
  import tew_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int         STALL_LIMIT   = 2000;
  localparam logic [1:0] EXIT_OTHER    = 2'd2;
  localparam logic [1:0] EXIT_RESERVED = 2'd3;
  localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;
  localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  tew_in_t                   in_data;
  logic                      out_valid;
  logic                      out_ready;
  tew_out_t                  out_data;
  logic                      cfg_en;
  logic [CFG_ADDR_WIDTH-1:0] cfg_addr;
  logic [CFG_WIDTH-1:0]      cfg_data;

  // watchdog model: configuration and state
  logic [31:0] timeout_reg;
  logic [31:0] grace_reg;
  logic        kill_reg;
  phase_t      mdl_phase;
  logic [31:0] mdl_count;
  logic [5:0]  mdl_intr_sig;

  tew_out_t expected_q[$];
  tew_out_t want;
  bit       steady;
  int       errors;
  int       items_sent;
  int       results_seen;
  int       signals_seen;
  int       finishes_seen;
  int       settings_seen;
  int       quiet_cycles;

  timeout_escalation_watchdog i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_en    (cfg_en),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic tew_out_t watchdog_predict(tew_in_t txn);
    tew_out_t   res;
    logic [8:0] wide_code;
    res = '0;
    if (txn.req_type == REQ_START) begin
      mdl_phase    = PH_RUN;
      mdl_count    = timeout_reg;
      mdl_intr_sig = '0;
      return res;
    end
    if (mdl_phase == PH_IDLE || txn.req_type > REQ_FAULT) return res;
    case (txn.req_type)
      REQ_TICK: begin
        if (mdl_count != 0) mdl_count = mdl_count - 32'd1;
        if (mdl_count == 0) begin
          case (mdl_phase)
            PH_RUN: begin
              res.send_signal = 1'b1;
              if (kill_reg) begin
                res.sig_num = SIG_KILL;
                mdl_phase   = PH_KILLED;
              end else begin
                res.sig_num = SIG_TERM;
                mdl_phase   = PH_TERM;
                mdl_count   = grace_reg;
              end
            end
            PH_TERM: begin
              res.send_signal = 1'b1;
              res.sig_num     = SIG_KILL;
              mdl_phase       = PH_KILLED;
            end
            PH_INTR: begin
              res.send_signal = 1'b1;
              res.sig_num     = SIG_KILL;
            end
            default: ;
          endcase
        end
      end
      REQ_SIGNAL: begin
        // only the first nonzero caller signal is forwarded
        if (txn.caller_sig != 0 && mdl_phase != PH_INTR) begin
          mdl_intr_sig    = txn.caller_sig;
          mdl_phase       = PH_INTR;
          mdl_count       = grace_reg;
          res.send_signal = 1'b1;
          res.sig_num     = txn.caller_sig;
        end
      end
      default: begin
        res.send_signal = 1'b1;
        res.sig_num     = SIG_KILL;
        res.finished    = 1'b1;
        if (txn.req_type == REQ_FAULT) begin
          res.exit_code = CODE_FAULT;
        end else begin
          case (mdl_phase)
            PH_RUN: begin
              case (txn.exit_kind)
                EXIT_NORMAL: res.exit_code = txn.exit_value;
                EXIT_SIGNAL: begin
                  wide_code     = {1'b0, CODE_SIGBASE} + {1'b0, txn.exit_value};
                  res.exit_code = wide_code[8] ? 8'hFF : wide_code[7:0];
                end
                default: res.exit_code = CODE_FAULT;
              endcase
            end
            PH_TERM:   res.exit_code = CODE_TIMEOUT;
            PH_KILLED: res.exit_code = CODE_KILLED;
            default:   res.exit_code = CODE_SIGBASE + {2'b00, mdl_intr_sig};
          endcase
        end
        mdl_phase    = PH_IDLE;
        mdl_count    = '0;
        mdl_intr_sig = '0;
      end
    endcase
    return res;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic tew_in_t txn_of(logic [2:0] req, logic [5:0] sig, logic [1:0] kind,
                                     logic [7:0] val);
    tew_in_t t;
    t.req_type   = req;
    t.caller_sig = sig;
    t.exit_kind  = kind;
    t.exit_value = val;
    return t;
  endfunction

  function automatic tew_in_t random_txn(logic [2:0] req);
    tew_in_t t;
    t.req_type   = req;
    t.caller_sig = ($urandom_range(0, 9) == 0) ? 6'd0 : 6'($urandom_range(1, 63));
    t.exit_kind  = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 5))
      0:       t.exit_value = 8'd0;
      1:       t.exit_value = 8'hFF;
      default: t.exit_value = 8'($urandom_range(0, 255));
    endcase
    return t;
  endfunction

  // Hold valid and payload until the transaction is taken, then predict it.
  task automatic send_txn(tew_in_t txn);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= txn;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(watchdog_predict(txn));
    items_sent++;
  endtask

  task automatic drain_results();
    if (in_valid) in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(logic [31:0] t, logic [31:0] g, logic k);
    cfg_en   <= 1'b1;
    cfg_addr <= CFG_TIMEOUT;
    cfg_data <= t;
    @(posedge clk);
    cfg_addr <= CFG_GRACE;
    cfg_data <= g;
    @(posedge clk);
    cfg_addr <= CFG_KILL;
    cfg_data <= {31'd0, k};
    @(posedge clk);
    cfg_en      <= 1'b0;
    timeout_reg = t;
    grace_reg   = g;
    kill_reg    = k;
    settings_seen++;
  endtask

  task automatic test_idle_requests();
    send_txn(txn_of(REQ_TICK, 6'd0, EXIT_NORMAL, 8'd0));
    send_txn(txn_of(REQ_SIGNAL, 6'd63, EXIT_SIGNAL, 8'hFF));
    send_txn(txn_of(REQ_FAULT, 6'd1, EXIT_RESERVED, 8'd1));
  endtask

  task automatic test_term_escalation();
    drain_results();
    set_config(32'd0, 32'd0, 1'b0);
    // zero timeout and zero grace expire on the next tick
    send_txn(txn_of(REQ_START, 6'd0, EXIT_NORMAL, 8'd0));
    send_txn(txn_of(REQ_TICK, 6'd0, EXIT_NORMAL, 8'd0));
    send_txn(txn_of(REQ_TICK, 6'd0, EXIT_NORMAL, 8'd0));
    send_txn(txn_of(REQ_TICK, 6'd0, EXIT_NORMAL, 8'd0));
    send_txn(txn_of(REQ_ENDED, 6'd0, EXIT_NORMAL, 8'd3));
    // zero caller signal, forwarded signal, then a second one dropped
    send_txn(txn_of(REQ_START, 6'd0, EXIT_NORMAL, 8'd0));
    send_txn(txn_of(REQ_SIGNAL, 6'd0, EXIT_NORMAL, 8'd0));
    send_txn(txn_of(REQ_SIGNAL, 6'd63, EXIT_NORMAL, 8'd0));
    send_txn(txn_of(REQ_TICK, 6'd0, EXIT_NORMAL, 8'd0));
    send_txn(txn_of(REQ_SIGNAL, 6'd2, EXIT_NORMAL, 8'd0));
    send_txn(txn_of(REQ_ENDED, 6'd0, EXIT_NORMAL, 8'd0));
  endtask

  task automatic test_kill_mode_exits();
    drain_results();
    set_config(32'd1, 32'd0, 1'b1);
    send_txn(txn_of(REQ_START, 6'd0, EXIT_NORMAL, 8'd0));
    send_txn(txn_of(REQ_TICK, 6'd0, EXIT_NORMAL, 8'd0));
    send_txn(txn_of(REQ_ENDED, 6'd0, EXIT_NORMAL, 8'd0));
    send_txn(txn_of(REQ_START, 6'd0, EXIT_NORMAL, 8'd0));
    send_txn(txn_of(REQ_UNUSED_HI, 6'd63, EXIT_SIGNAL, 8'hFF));
    send_txn(txn_of(REQ_ENDED, 6'd0, EXIT_NORMAL, 8'hFF));
    send_txn(txn_of(REQ_START, 6'd0, EXIT_NORMAL, 8'd0));
    send_txn(txn_of(REQ_ENDED, 6'd0, EXIT_SIGNAL, 8'd200));
    send_txn(txn_of(REQ_START, 6'd0, EXIT_NORMAL, 8'd0));
    send_txn(txn_of(REQ_ENDED, 6'd0, EXIT_OTHER, 8'd7));
    send_txn(txn_of(REQ_START, 6'd0, EXIT_NORMAL, 8'd0));
    send_txn(txn_of(REQ_START, 6'd0, EXIT_NORMAL, 8'd0));
    send_txn(txn_of(REQ_FAULT, 6'd0, EXIT_NORMAL, 8'd0));
  endtask

  task automatic test_wide_counts();
    drain_results();
    set_config(COUNT_MAX, COUNT_MAX, 1'b0);
    send_txn(txn_of(REQ_START, 6'd0, EXIT_NORMAL, 8'd0));
    send_txn(txn_of(REQ_TICK, 6'd0, EXIT_NORMAL, 8'd0));
    send_txn(txn_of(REQ_ENDED, 6'd0, EXIT_SIGNAL, 8'd0));
  endtask

  // One supervision: start, a run of mostly ticks, then usually an end.
  task automatic run_session();
    longint unsigned budget;
    int              steps;
    int              roll;
    budget = 64'(timeout_reg) + 64'(grace_reg) + 4;
    if (budget > 16) budget = 16;
    send_txn(random_txn(REQ_START));
    steps = $urandom_range(0, int'(budget));
    repeat (steps) begin
      roll = $urandom_range(0, 99);
      if (roll < 78) send_txn(random_txn(REQ_TICK));
      else if (roll < 90) send_txn(random_txn(REQ_SIGNAL));
      else if (roll < 94) send_txn(random_txn(REQ_START));
      else if (roll < 97)
        send_txn(random_txn(3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI))));
      else send_txn(random_txn(3'($urandom_range(0, 7))));
    end
    roll = $urandom_range(0, 99);
    if (roll < 75) send_txn(random_txn(REQ_ENDED));
    else if (roll < 92) send_txn(random_txn(REQ_FAULT));
    if ($urandom_range(0, 19) == 0) send_txn(random_txn(3'($urandom_range(0, 7))));
  endtask

  task automatic run_phase(logic [31:0] t, logic [31:0] g, logic k, int n_items, bit no_idle);
    int target;
    drain_results();
    set_config(t, g, k);
    steady = no_idle;
    target = items_sent + n_items;
    while (items_sent < target) begin
      run_session();
      // now and then hold off until the output side is empty
      if ($urandom_range(0, 29) == 0) drain_results();
    end
    steady = 1'b0;
  endtask

  task automatic test_random_phases();
    logic [31:0] t;
    logic [31:0] g;
    run_phase(32'd0, 32'd0, 1'b0, 300, 1'b0);
    run_phase(32'd0, 32'd0, 1'b1, 200, 1'b0);
    run_phase($urandom_range(1, 6), $urandom_range(0, 6), 1'b0, 300, 1'b0);
    run_phase($urandom_range(1, 6), $urandom_range(0, 6), 1'b1, 250, 1'b1);
    run_phase(COUNT_MAX, $urandom_range(0, 3), 1'b0, 100, 1'b0);
    run_phase($urandom_range(0, 3), COUNT_MAX, 1'b0, 100, 1'b0);
    repeat (2) begin
      t = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 5);
      g = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 5);
      run_phase(t, g, 1'($urandom_range(0, 1)), 175, 1'b0);
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction: %p", out_data);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_data.send_signal !== want.send_signal) begin
          $error("send_signal: expected %0d, got %0d", want.send_signal, out_data.send_signal);
          errors++;
        end
        if (out_data.sig_num !== want.sig_num) begin
          $error("sig_num: expected %0d, got %0d", want.sig_num, out_data.sig_num);
          errors++;
        end
        if (out_data.finished !== want.finished) begin
          $error("finished: expected %0d, got %0d", want.finished, out_data.finished);
          errors++;
        end
        if (out_data.exit_code !== want.exit_code) begin
          $error("exit_code: expected %0d, got %0d", want.exit_code, out_data.exit_code);
          errors++;
        end
        if (want.send_signal) signals_seen++;
        if (want.finished) finishes_seen++;
      end
    end
  end

  // Output-side backpressure: runs of ready with random stalls between them.
  initial begin : sink_stall
    int run_len;
    int stall_len;
    out_ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      run_len = $urandom_range(1, 20);
      out_ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      stall_len = pick_gap();
      if (stall_len > 0) begin
        out_ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  // End the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    in_data      <= '0;
    cfg_en       <= 1'b0;
    cfg_addr     <= CFG_TIMEOUT;
    cfg_data     <= '0;
    timeout_reg  = '0;
    grace_reg    = '0;
    kill_reg     = 1'b0;
    mdl_phase    = PH_IDLE;
    mdl_count    = '0;
    mdl_intr_sig = '0;
    steady       = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_requests();
    test_term_escalation();
    test_kill_mode_exits();
    test_wide_counts();
    test_random_phases();

    drain_results();
    repeat (4) @(posedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_q.size());
      errors++;
    end
    $display("covered %0d input transactions and %0d results over %0d register settings",
             items_sent, results_seen, settings_seen);
    $display("results carried %0d signals and %0d finished supervisions",
             signals_seen, finishes_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/tew_pkg.sv
hdl/tew_core.sv
hdl/timeout_escalation_watchdog.sv
dv/testbench.sv
